// ===== hdl/ladq_pkg.sv =====
// shared constants, types and codes for the linear array deque
`default_nettype none

package ladq_pkg;

  localparam int DEPTH    = 8;
  localparam int IDX_W    = $clog2(DEPTH + 1);
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int IN_TDATA_W  = ((OP_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ST_W + DATA_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INS_REAR  = 2'd0,
    OP_DEL_REAR  = 2'd1,
    OP_INS_FRONT = 2'd2,
    OP_DEL_FRONT = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic exec;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/linear_array_deque.sv =====
// top level of the linear array deque: controller plus datapath
// result path: execute edge, then load edge once the output register is free
// a new input transaction is not accepted until the previous result has been loaded
// a new input transaction is taken while a finished result still waits at the output
// reset: synchronous active-low rst_n clears indices, state and output valid
// slot contents are not cleared; a slot is always written before it is read
`default_nettype none

module linear_array_deque
  import ladq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input transaction: [1:0] operation, [33:2] value, [39:34] zero
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // result transaction: [1:0] status, [33:2] removed_value, [39:34] zero
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: accepts in idle, then waits for a free output register
  ladq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: index update and slot access on execute, result capture on load
  ladq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/ladq_ctrl.sv =====
// controller state machine: sequences execute and result load
`default_nettype none

module ladq_ctrl
  import ladq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.exec  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        // wait for the output register to free up
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ladq_dp.sv =====
// datapath: front and rear indices, slot memory and output register
`default_nettype none

module ladq_dp
  import ladq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire dp_cmd_t                cmd,
  output dp_stat_t                    stat,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  op_t               op;
  logic [DATA_W-1:0] value;
  logic              empty;
  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [IDX_W-1:0]  rear_r, rear_nxt;
  logic [IDX_W-1:0]  front_m1, rear_m1;
  status_t           st;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_idx, rd_idx;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  status_t           st_r;
  logic              del_ok_r;
  logic [DATA_W-1:0] removed;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  assign op       = op_t'(in_tdata[OP_W-1:0]);
  assign value    = in_tdata[OP_W+DATA_W-1:OP_W];
  assign empty    = front_r >= rear_r;
  assign front_m1 = front_r - IDX_W'(1);
  assign rear_m1  = rear_r - IDX_W'(1);

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    st        = ST_OK;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_idx    = rear_r;
    rd_idx    = front_r;
    unique case (op)
      OP_INS_REAR: begin
        if (rear_r == IDX_W'(DEPTH)) begin
          st = ST_OVER;
        end else begin
          wr_en    = 1'b1;
          wr_idx   = rear_r;
          rear_nxt = rear_r + IDX_W'(1);
        end
      end
      OP_DEL_REAR: begin
        if (empty) begin
          st = ST_UNDER;
        end else begin
          rd_en    = 1'b1;
          rd_idx   = rear_m1;
          rear_nxt = rear_m1;
        end
      end
      OP_INS_FRONT: begin
        if (front_r == '0) begin
          st = ST_OVER;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = front_m1;
          front_nxt = front_m1;
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          st = ST_UNDER;
        end else begin
          rd_en     = 1'b1;
          rd_idx    = front_r;
          front_nxt = front_r + IDX_W'(1);
        end
      end
      default: begin
        st = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_idx[ADDR_W-1:0]] <= value;
    end
    if (cmd.exec && rd_en) begin
      rdata_r <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_r     <= st;
      del_ok_r <= rd_en;
    end
  end

  assign removed = del_ok_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tdata_r <= {{(OUT_TDATA_W-ST_W-DATA_W){1'b0}}, removed, st_r};
    end
  end

  assign out_tvalid    = out_tvalid_r;
  assign out_tdata     = out_tdata_r;
  assign stat.out_free = !out_tvalid_r || out_tready;

  a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
    (front_r <= rear_r) && (rear_r <= IDX_W'(DEPTH)))
    else $error("deque indices out of order");

  a_refused_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (st != ST_OK)) |=> ($stable(front_r) && $stable(rear_r)))
    else $error("refused transaction moved an index");

  a_del_front_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (op == OP_DEL_FRONT) && !empty)
      |=> (front_r == $past(front_r) + IDX_W'(1)))
    else $error("front delete did not advance front index");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_tvalid_r)
    else $error("loaded result not presented");

endmodule

`default_nettype wire
